>>> sv/conv1d_stride_pad_macros.svh
// Assertion macros shared by the conv1d_stride_pad RTL.
// No dependencies; included by the files that carry assertions.
`ifndef CONV1D_STRIDE_PAD_MACROS_SVH
`define CONV1D_STRIDE_PAD_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define C1D_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define C1D_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/c1d_pkg.sv
// Package for conv1d_stride_pad: sizes, codes, payload and control types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package c1d_pkg;

    localparam int MAX_IN_CH   = 16;
    localparam int MAX_OUT_CH  = 16;
    localparam int MAX_KERNEL  = 8;
    localparam int MAX_SEQ_LEN = 4096;
    localparam int MAX_RESULTS = 64;

    localparam int ACC_W   = 40;
    localparam int QDEPTH  = 4;
    localparam int WDEPTH  = MAX_OUT_CH * MAX_KERNEL * MAX_IN_CH;
    localparam int XDEPTH  = MAX_KERNEL * MAX_IN_CH;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_IN_CH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_CH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD    = 3'd4;

    typedef enum logic [1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_WEIGHT = 2'd1,
        REQ_BIAS   = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef struct packed {
        t_req               req_type;
        logic signed [15:0] sample_value;
        logic               sample_last;
        logic [2:0]         tap_index;
        logic [3:0]         in_channel_index;
        logic [3:0]         out_channel_index;
        logic signed [15:0] coefficient;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] result_value;
        logic [12:0]        result_position;
        logic [3:0]         result_channel;
        logic               run_last;
        logic               status;
    } t_out_item;

    // Effective configuration, already clamped to legal ranges.
    typedef struct packed {
        logic [4:0] ic;
        logic [4:0] oc;
        logic [3:0] kt;
        logic [3:0] ws;
        logic [1:0] pad;
    } t_cfg;

    typedef struct packed {
        logic        is_err;
        logic        last;
        logic [13:0] start;
        logic [12:0] oidx;
        logic [12:0] len;
    } t_job;

    // Store writes from the front end to the coefficient and window stores.
    typedef struct packed {
        logic        we_w;
        logic [10:0] w_addr;
        logic        we_b;
        logic [3:0]  b_addr;
        logic [15:0] coef;
        logic        we_x;
        logic [2:0]  x_slot;
        logic [3:0]  x_ch;
        logic [15:0] x_val;
        logic        clr_x;
    } t_wr;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DRAIN,
        F_SEQEND
    } t_fstate;

    typedef enum logic [2:0] {
        B_CLR,
        B_IDLE,
        B_INIT,
        B_MAC,
        B_WAIT
    } t_bstate;

endpackage

>>> sv/c1d_jobq.sv
// Four-entry job queue between the front end and the MAC back end.
// Depends on c1d_pkg for the job type and depth.
`timescale 1ns / 1ps

module c1d_jobq import c1d_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty,
    output logic o_full
);

    t_job                      r_q [QDEPTH];
    logic [$clog2(QDEPTH)-1:0] r_wp;
    logic [$clog2(QDEPTH)-1:0] r_rp;
    logic [$clog2(QDEPTH):0]   r_cnt;

    logic do_push;
    logic do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == ($clog2(QDEPTH)+1)'(QDEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> sv/c1d_front.sv
// Front end: accepts requests, tracks sequence position and emits window jobs.
// Depends on c1d_pkg; feeds c1d_jobq and the store write port of c1d_back.
`timescale 1ns / 1ps

module c1d_front import c1d_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    input  logic     i_q_empty,
    input  logic     i_q_full,
    input  logic     i_back_idle,
    output logic     o_job_push,
    output t_job     o_job,
    output t_wr      o_wr
);

    t_fstate     r_state, n_state;
    logic [12:0] r_pc, n_pc;
    logic [3:0]  r_cc, n_cc;
    logic [13:0] r_start, n_start;
    logic [12:0] r_oidx, n_oidx;
    logic [13:0] r_limit1, n_limit1;
    logic [6:0]  r_nres, n_nres;
    logic        r_last, n_last;

    logic        can_acc;
    logic        accept;
    logic [12:0] pc1;
    logic [13:0] total;
    logic        exists;
    logic        nxt_exists;
    logic        emit;
    logic        more;

    assign can_acc = (r_state == F_IDLE) && i_back_idle && i_q_empty;
    assign o_full  = !can_acc;
    assign accept  = i_push && can_acc;

    assign pc1   = (r_pc < 13'(MAX_SEQ_LEN)) ? r_pc + 13'd1 : r_pc;
    assign total = 14'(pc1) + 14'({i_cfg.pad, 1'b0});

    assign exists     = (15'(r_start) + 15'(i_cfg.kt)) <= 15'(r_limit1);
    assign nxt_exists = (15'(r_start) + 15'(i_cfg.ws) + 15'(i_cfg.kt)) <= 15'(r_limit1);
    assign emit       = (8'(r_nres) + 8'(i_cfg.oc)) <= 8'(MAX_RESULTS);
    assign more       = nxt_exists && ((8'(r_nres) + 8'({i_cfg.oc, 1'b0})) <= 8'(MAX_RESULTS));

    always_comb begin
        n_state    = r_state;
        n_pc       = r_pc;
        n_cc       = r_cc;
        n_start    = r_start;
        n_oidx     = r_oidx;
        n_limit1   = r_limit1;
        n_nres     = r_nres;
        n_last     = r_last;
        o_wr       = '0;
        o_job_push = 1'b0;
        o_job      = '0;
        o_job.start = r_start;
        o_job.oidx  = r_oidx;
        o_job.len   = r_pc;

        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    case (i_item.req_type)
                        REQ_WEIGHT: begin
                            o_wr.we_w   = 1'b1;
                            o_wr.w_addr = {i_item.out_channel_index, i_item.tap_index,
                                           i_item.in_channel_index};
                            o_wr.coef   = i_item.coefficient;
                        end
                        REQ_BIAS: begin
                            o_wr.we_b   = 1'b1;
                            o_wr.b_addr = i_item.out_channel_index;
                            o_wr.coef   = i_item.coefficient;
                        end
                        REQ_SAMPLE: begin
                            if (r_pc < 13'(MAX_SEQ_LEN)) begin
                                o_wr.we_x   = 1'b1;
                                o_wr.x_slot = r_pc[2:0] + 3'(i_cfg.pad);
                                o_wr.x_ch   = r_cc;
                                o_wr.x_val  = i_item.sample_value;
                            end
                            if ((5'(r_cc) + 5'd1 >= i_cfg.ic) || i_item.sample_last) begin
                                n_cc   = '0;
                                n_pc   = pc1;
                                n_nres = '0;
                                if (i_item.sample_last) begin
                                    if (total < 14'(i_cfg.kt)) begin
                                        // Too short for any window: one error result.
                                        o_job_push   = 1'b1;
                                        o_job.is_err = 1'b1;
                                        o_job.last   = 1'b1;
                                        n_state      = F_SEQEND;
                                    end else begin
                                        n_limit1 = total;
                                        n_last   = 1'b1;
                                        n_state  = F_DRAIN;
                                    end
                                end else begin
                                    n_limit1 = 14'(pc1) + 14'(i_cfg.pad);
                                    n_last   = 1'b0;
                                    n_state  = F_DRAIN;
                                end
                            end else begin
                                n_cc = r_cc + 4'd1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            F_DRAIN: begin
                if (!exists) begin
                    n_state = r_last ? F_SEQEND : F_IDLE;
                end else if (!emit || !i_q_full) begin
                    // A window that would overrun the result budget is counted only.
                    if (emit) begin
                        o_job_push = 1'b1;
                        o_job.last = !more;
                        n_nres     = r_nres + 7'(i_cfg.oc);
                    end
                    n_start = r_start + 14'(i_cfg.ws);
                    n_oidx  = r_oidx + 13'd1;
                end
            end
            F_SEQEND: begin
                // The window store is cleared only once queued windows have been read.
                if (i_back_idle && i_q_empty) begin
                    o_wr.clr_x = 1'b1;
                    n_pc       = '0;
                    n_start    = '0;
                    n_oidx     = '0;
                    n_state    = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_pc     <= '0;
            r_cc     <= '0;
            r_start  <= '0;
            r_oidx   <= '0;
            r_limit1 <= '0;
            r_nres   <= '0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pc     <= n_pc;
            r_cc     <= n_cc;
            r_start  <= n_start;
            r_oidx   <= n_oidx;
            r_limit1 <= n_limit1;
            r_nres   <= n_nres;
            r_last   <= n_last;
        end
    end

endmodule

>>> sv/c1d_back.sv
// Back end: coefficient and window stores, one shared MAC, result buffer.
// Depends on c1d_pkg and conv1d_stride_pad_macros.svh; fed by c1d_jobq.
`timescale 1ns / 1ps
`include "conv1d_stride_pad_macros.svh"

module c1d_back import c1d_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_wr       i_wr,
    input  t_job      i_job,
    input  logic      i_q_empty,
    output logic      o_job_pop,
    output logic      o_idle,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_result
);

    logic [15:0] r_wmem [WDEPTH];
    logic [15:0] r_xmem [XDEPTH];
    logic [15:0] r_bias [MAX_OUT_CH];
    logic [4:0]  r_fill [MAX_KERNEL];

    t_bstate     r_state, n_state;
    logic [10:0] r_clr;
    t_job        r_job;
    logic [3:0]  r_o;
    logic [2:0]  r_k;
    logic [3:0]  r_c;
    logic [15:0] r_wrd;
    logic [15:0] r_xrd;
    logic        r_s1_ok;
    logic        r_s1_last;
    logic        r_s2_last;
    logic        r_s3_done;
    logic signed [31:0]      r_prod;
    logic signed [ACC_W-1:0] r_acc;
    t_out_item   r_res;
    logic        r_res_v;
    t_out_item   r_ofifo [2];
    logic        r_orp;
    logic        r_owp;
    logic [1:0]  r_ocnt;

    logic [14:0] q;
    logic [2:0]  slot;
    logic        ok_x;
    logic        c_wrap;
    logic        last_issue;
    logic        o_last;
    logic        push;
    logic        do_pop;
    logic signed [ACC_W-1:0] rsum;
    logic signed [ACC_W-1:0] rq;
    logic signed [15:0]      sat;

    assign q      = 15'(r_job.start) + 15'(r_k);
    assign slot   = q[2:0];
    assign ok_x   = (q >= 15'(i_cfg.pad)) && (q < 15'(i_cfg.pad) + 15'(r_job.len))
                    && (5'(r_c) < r_fill[slot]);
    assign c_wrap     = (5'(r_c) + 5'd1 == i_cfg.ic);
    assign last_issue = c_wrap && (4'(r_k) + 4'd1 == i_cfg.kt);
    assign o_last     = (5'(r_o) + 5'd1 == i_cfg.oc);

    // Round half up, then saturate to Q8.8.
    assign rsum = r_acc + ACC_W'(2048);
    assign rq   = rsum >>> 12;
    assign sat  = (rq > ACC_W'(32767)) ? 16'sh7fff :
                  (rq < -ACC_W'(32768)) ? 16'sh8000 : rq[15:0];

    assign push     = (r_state == B_WAIT) && r_res_v && (r_ocnt != 2'd2);
    assign do_pop   = i_pop && !o_empty;
    assign o_empty  = (r_ocnt == 2'd0);
    assign o_result = r_ofifo[r_orp];
    assign o_idle   = (r_state == B_IDLE);

    always_comb begin
        n_state   = r_state;
        o_job_pop = 1'b0;
        case (r_state)
            B_CLR: begin
                if (r_clr == '1) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!i_q_empty) begin
                    o_job_pop = 1'b1;
                    n_state   = i_job.is_err ? B_WAIT : B_INIT;
                end
            end
            B_INIT: n_state = B_MAC;
            B_MAC: begin
                if (last_issue) begin
                    n_state = B_WAIT;
                end
            end
            B_WAIT: begin
                if (push) begin
                    n_state = (r_job.is_err || o_last) ? B_IDLE : B_INIT;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Stores: weight memory is swept to zero after reset.
    always_ff @(posedge i_clk) begin
        if (r_state == B_CLR) begin
            r_wmem[r_clr] <= '0;
        end else if (i_wr.we_w) begin
            r_wmem[i_wr.w_addr] <= i_wr.coef;
        end
        r_wrd <= r_wmem[{r_o, r_k, r_c}];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we_x) begin
            r_xmem[{i_wr.x_slot, i_wr.x_ch}] <= i_wr.x_val;
        end
        r_xrd <= r_xmem[{slot, r_c}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_OUT_CH; i++) begin
                r_bias[i] <= '0;
            end
            for (int i = 0; i < MAX_KERNEL; i++) begin
                r_fill[i] <= '0;
            end
        end else begin
            if (i_wr.we_b) begin
                r_bias[i_wr.b_addr] <= i_wr.coef;
            end
            // Entries at or above a row's fill count read as zero.
            if (i_wr.clr_x) begin
                for (int i = 0; i < MAX_KERNEL; i++) begin
                    r_fill[i] <= '0;
                end
            end else if (i_wr.we_x) begin
                r_fill[i_wr.x_slot] <= 5'(i_wr.x_ch) + 5'd1;
            end
        end
    end

    // Datapath: issue, multiply, accumulate, and stage results into the result buffer.
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
            r_o   <= '0;
        end
        if (r_state == B_WAIT && push && !o_last) begin
            r_o <= r_o + 4'd1;
        end
        if (r_state == B_INIT) begin
            r_k   <= '0;
            r_c   <= '0;
            r_acc <= {{(ACC_W-28){r_bias[r_o][15]}}, r_bias[r_o], 12'b0};
        end else begin
            r_acc <= r_acc + {{(ACC_W-32){r_prod[31]}}, r_prod};
            if (r_state == B_MAC) begin
                if (c_wrap) begin
                    r_c <= '0;
                    r_k <= r_k + 3'd1;
                end else begin
                    r_c <= r_c + 4'd1;
                end
            end
        end
        r_prod <= r_s1_ok ? $signed(r_xrd) * $signed(r_wrd) : 32'sd0;
        if (r_s3_done) begin
            r_res.result_value    <= sat;
            r_res.result_position <= r_job.oidx;
            r_res.result_channel  <= r_o;
            r_res.run_last        <= r_job.last && o_last;
            r_res.status          <= 1'b0;
        end else if (o_job_pop && i_job.is_err) begin
            r_res.result_value    <= '0;
            r_res.result_position <= '0;
            r_res.result_channel  <= '0;
            r_res.run_last        <= 1'b1;
            r_res.status          <= 1'b1;
        end
        if (push) begin
            r_ofifo[r_owp] <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_CLR;
            r_clr     <= '0;
            r_s1_ok   <= 1'b0;
            r_s1_last <= 1'b0;
            r_s2_last <= 1'b0;
            r_s3_done <= 1'b0;
            r_res_v   <= 1'b0;
            r_orp     <= 1'b0;
            r_owp     <= 1'b0;
            r_ocnt    <= '0;
        end else begin
            r_state   <= n_state;
            if (r_state == B_CLR) begin
                r_clr <= r_clr + 11'd1;
            end
            r_s1_ok   <= (r_state == B_MAC) && ok_x;
            r_s1_last <= (r_state == B_MAC) && last_issue;
            r_s2_last <= r_s1_last;
            r_s3_done <= r_s2_last;
            if (r_s3_done || (o_job_pop && i_job.is_err)) begin
                r_res_v <= 1'b1;
            end else if (push) begin
                r_res_v <= 1'b0;
            end
            if (push) begin
                r_owp <= !r_owp;
            end
            if (do_pop) begin
                r_orp <= !r_orp;
            end
            case ({push, do_pop})
                2'b10:   r_ocnt <= r_ocnt + 2'd1;
                2'b01:   r_ocnt <= r_ocnt - 2'd1;
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

    `C1D_ASSERT_IMP(a_ofifo_bound, i_clk, i_rst_n, 1'b1, r_ocnt <= 2'd2, "result buffer overrun")
    `C1D_ASSERT_IMP(a_pop_idle, i_clk, i_rst_n, o_job_pop, r_state == B_IDLE, "job taken while busy")
    `C1D_ASSERT_IMP(a_done_wait, i_clk, i_rst_n, r_s3_done, r_state == B_WAIT, "sum done outside wait")
    `C1D_ASSERT_NXT(a_res_drain, i_clk, i_rst_n, push, !r_res_v, "staged result not released")

endmodule

>>> sv/conv1d_stride_pad.sv
// Multichannel 1D convolution with bias, stride and zero padding at both ends.
// Input channel: a request is transferred when push is high and full is low. Samples
// come position by position, channels in order; weight and bias writes load the stores.
// Result channel: the oldest result sits on o_result while empty is low and is
// transferred when pop is high. A two-entry result buffer keeps the MAC running while
// the receiver stalls; when it fills, the MAC waits and full stays high.
// After reset all 2048 weight store entries are swept to zero, full high throughout.
// Each output value accumulates one product per kernel tap and used input channel on
// the single multiplier, between bias setup and the pipeline fill and result handoff;
// a window is taken from the job queue and then computes each used output channel in
// turn. Coefficient writes and samples that do not complete a position leave the front
// end ready for the next request; a sample that completes a position first passes the
// drain state. A request is taken only once all earlier windows have been computed; a
// request after the last sample of a sequence also waits for the window store release.
// Configuration: i_cfg_we, i_cfg_idx, i_cfg_data, written while the block is idle.
// Depends on c1d_pkg, c1d_front, c1d_jobq and c1d_back.
`timescale 1ns / 1ps

module conv1d_stride_pad import c1d_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    input  t_in_item              i_item,
    output logic                  full,
    output logic                  empty,
    input  logic                  pop,
    output t_out_item             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [4:0] r_ic;
    logic [4:0] r_oc;
    logic [3:0] r_kt;
    logic [3:0] r_ws;
    logic [1:0] r_pad;
    t_cfg       cfg;

    logic q_push, q_pop, q_empty, q_full, back_idle;
    t_job q_in, q_out;
    t_wr  wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ic  <= 5'd1;
            r_oc  <= 5'd1;
            r_kt  <= 4'd3;
            r_ws  <= 4'd1;
            r_pad <= 2'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IN_CH:  r_ic  <= i_cfg_data;
                CFG_OUT_CH: r_oc  <= i_cfg_data;
                CFG_KT:     r_kt  <= i_cfg_data[3:0];
                CFG_WS:     r_ws  <= i_cfg_data[3:0];
                CFG_PAD:    r_pad <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.ic  = (r_ic == '0) ? 5'd1 : (r_ic > 5'(MAX_IN_CH)) ? 5'(MAX_IN_CH) : r_ic;
        cfg.oc  = (r_oc == '0) ? 5'd1 : (r_oc > 5'(MAX_OUT_CH)) ? 5'(MAX_OUT_CH) : r_oc;
        cfg.kt  = (r_kt == '0) ? 4'd1 : (r_kt > 4'(MAX_KERNEL)) ? 4'(MAX_KERNEL) : r_kt;
        cfg.ws  = (r_ws == '0) ? 4'd1 : r_ws;
        cfg.pad = r_pad;
    end

    c1d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .i_q_empty   (q_empty),
        .i_q_full    (q_full),
        .i_back_idle (back_idle),
        .o_job_push  (q_push),
        .o_job       (q_in),
        .o_wr        (wr)
    );

    c1d_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .i_pop   (q_pop),
        .o_job   (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    c1d_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_wr      (wr),
        .i_job     (q_out),
        .i_q_empty (q_empty),
        .o_job_pop (q_pop),
        .o_idle    (back_idle),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_result  (o_result)
    );

endmodule

>>> sim/conv1d_checker.sv
// Result checker for conv1d_stride_pad: watches the request, result and configuration ports,
// predicts the expected results and compares every result transfer with them.
// Depends on c1d_pkg.
`timescale 1ns / 1ps

module conv1d_checker import c1d_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    input  logic                  full,
    input  t_in_item              i_item,
    input  logic                  empty,
    input  logic                  pop,
    input  t_out_item             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending
);

    logic [15:0] x_hist [XDEPTH];
    logic [15:0] weights [WDEPTH];
    logic [15:0] biases [MAX_OUT_CH];
    int unsigned pos_count, chan_count, win_start, out_pos;
    logic [4:0]  r_ic, r_oc;
    logic [3:0]  r_kt, r_ws;
    logic [1:0]  r_pad;
    t_out_item   conv_expected [$];
    int          n_out;
    int          err_count;

    assign o_errors = err_count;

    function automatic int clampi(input int v, input int lo, input int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic clear_model();
        foreach (x_hist[i]) x_hist[i] = '0;
        foreach (weights[i]) weights[i] = '0;
        foreach (biases[i]) biases[i] = '0;
        pos_count = 0;
        chan_count = 0;
        win_start = 0;
        out_pos = 0;
        r_ic = 5'd1;
        r_oc = 5'd1;
        r_kt = 4'd3;
        r_ws = 4'd1;
        r_pad = 2'd1;
        conv_expected.delete();
    endtask

    // Computes every window whose last padded position is at most limit.
    task automatic emit_windows(input longint limit);
        int ic, oc, kt, ws, pad, len, slot;
        longint acc, q;
        t_out_item r;
        ic = clampi(r_ic, 1, MAX_IN_CH);
        oc = clampi(r_oc, 1, MAX_OUT_CH);
        kt = clampi(r_kt, 1, MAX_KERNEL);
        ws = (r_ws == 0) ? 1 : r_ws;
        pad = r_pad;
        len = pos_count;
        while (longint'(win_start) + kt - 1 <= limit) begin
            // A window that does not fit in the results of this request is dropped.
            if (n_out + oc <= MAX_RESULTS) begin
                for (int o = 0; o < oc; o++) begin
                    acc = longint'($signed(biases[o])) * 4096;
                    for (int k = 0; k < kt; k++) begin
                        q = longint'(win_start) + k;
                        if (q >= pad && q < pad + len) begin
                            slot = q % MAX_KERNEL;
                            for (int c = 0; c < ic; c++) begin
                                acc += longint'($signed(x_hist[slot * MAX_IN_CH + c]))
                                     * longint'($signed(weights[(o * MAX_KERNEL + k)
                                                                * MAX_IN_CH + c]));
                            end
                        end
                    end
                    acc = (acc + 2048) >>> 12;
                    if (acc > 32767) acc = 32767;
                    if (acc < -32768) acc = -32768;
                    r.result_value = acc[15:0];
                    r.result_position = out_pos[12:0];
                    r.result_channel = o[3:0];
                    r.run_last = 1'b0;
                    r.status = 1'b0;
                    conv_expected.insert(conv_expected.size(), r);
                    n_out++;
                end
            end
            win_start += ws;
            out_pos++;
        end
    endtask

    task automatic predict_request(input t_in_item it);
        int ic, kt, pad, slot;
        longint total;
        t_out_item r;
        n_out = 0;
        case (it.req_type)
            REQ_WEIGHT: begin
                weights[{it.out_channel_index, it.tap_index, it.in_channel_index}] =
                    it.coefficient;
            end
            REQ_BIAS: begin
                biases[it.out_channel_index] = it.coefficient;
            end
            REQ_SAMPLE: begin
                ic = clampi(r_ic, 1, MAX_IN_CH);
                kt = clampi(r_kt, 1, MAX_KERNEL);
                pad = r_pad;
                if (pos_count < MAX_SEQ_LEN) begin
                    slot = (pos_count + pad) % MAX_KERNEL;
                    if (chan_count == 0) begin
                        for (int c = 0; c < MAX_IN_CH; c++) x_hist[slot * MAX_IN_CH + c] = '0;
                    end
                    x_hist[slot * MAX_IN_CH + chan_count] = it.sample_value;
                end
                if (chan_count + 1 >= ic || it.sample_last) begin
                    chan_count = 0;
                    if (pos_count < MAX_SEQ_LEN) pos_count++;
                    if (it.sample_last) begin
                        total = longint'(pos_count) + 2 * pad;
                        if (total < kt) begin
                            r = '0;
                            r.status = 1'b1;
                            conv_expected.insert(conv_expected.size(), r);
                            n_out = 1;
                        end else begin
                            emit_windows(total - 1);
                        end
                        foreach (x_hist[i]) x_hist[i] = '0;
                        pos_count = 0;
                        win_start = 0;
                        out_pos = 0;
                    end else begin
                        emit_windows(longint'(pad) + pos_count - 1);
                    end
                end else begin
                    chan_count++;
                end
            end
            default: ;
        endcase
        if (n_out > 0) conv_expected[conv_expected.size() - 1].run_last = 1'b1;
    endtask

    task automatic flag(input string what, input t_out_item got, input t_out_item want);
        err_count++;
        if (err_count <= 10) begin
            $display("%0t %s: got value %0d pos %0d ch %0d last %0b status %0b,",
                     $realtime, what, got.result_value, got.result_position,
                     got.result_channel, got.run_last, got.status,
                     " expected value %0d pos %0d ch %0d last %0b status %0b",
                     want.result_value, want.result_position, want.result_channel,
                     want.run_last, want.status);
        end
    endtask

    initial err_count = 0;

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            clear_model();
        end else begin
            if (pop && !empty) begin
                if (conv_expected.size() == 0) begin
                    flag("unexpected result", o_result, '0);
                end else begin
                    want = conv_expected.pop_front();
                    if (o_result.result_value !== want.result_value
                        || o_result.result_position !== want.result_position
                        || o_result.result_channel !== want.result_channel
                        || o_result.run_last !== want.run_last
                        || o_result.status !== want.status) begin
                        flag("result mismatch", o_result, want);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IN_CH:  r_ic = i_cfg_data;
                    CFG_OUT_CH: r_oc = i_cfg_data;
                    CFG_KT:     r_kt = i_cfg_data[3:0];
                    CFG_WS:     r_ws = i_cfg_data[3:0];
                    CFG_PAD:    r_pad = i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (push && !full) predict_request(i_item);
        end
        o_pending <= conv_expected.size();
    end

endmodule

>>> sim/testbench.sv
// Top of the conv1d_stride_pad testbench: clock, reset, request and configuration stimulus,
// result stalls and the verdict. Depends on c1d_pkg, conv1d_stride_pad and conv1d_checker.
`timescale 1ns / 1ps

module testbench;
    import c1d_pkg::*;

    localparam int STALL_LIMIT = 30000;
    localparam int SETTLE_CYCLES = 2200;
    localparam int RANDOM_ITEMS = 210;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    t_in_item              i_item = '0;
    logic                  full;
    logic                  empty;
    logic                  pop = 1'b0;
    t_out_item             o_result;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    int                    errors;
    int                    pending;

    int cur_ic = 1, cur_oc = 1, cur_kt = 3;
    int burst_left = 1;
    int n_sent = 0;
    int idle_cycles = 0;
    int rx_cycle = 0;
    int rx_mode = 0;

    conv1d_stride_pad dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .i_item(i_item), .full(full),
        .empty(empty), .pop(pop), .o_result(o_result), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    conv1d_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_item(i_item),
        .empty(empty), .pop(pop), .o_result(o_result), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data), .o_errors(errors),
        .o_pending(pending)
    );

    always #10 i_clk = ~i_clk;

    // The receiver switches among steady, random and mostly stalled popping.
    always @(posedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 256 == 0) rx_mode = $urandom_range(0, 2);
        case (rx_mode)
            0: pop <= 1'b1;
            1: pop <= 1'($urandom_range(0, 1));
            default: pop <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(0, 2047)) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_item rand_bits();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[45:0];
    endfunction

    function automatic t_in_item mk_sample(input logic [15:0] v, input logic last);
        t_in_item it;
        it = rand_bits();
        it.req_type = REQ_SAMPLE;
        it.sample_value = v;
        it.sample_last = last;
        return it;
    endfunction

    function automatic t_in_item mk_weight(input int o, input int k, input int c,
                                           input logic [15:0] coef);
        t_in_item it;
        it = rand_bits();
        it.req_type = REQ_WEIGHT;
        it.out_channel_index = 4'(o);
        it.tap_index = 3'(k);
        it.in_channel_index = 4'(c);
        it.coefficient = coef;
        return it;
    endfunction

    function automatic t_in_item mk_bias(input int o, input logic [15:0] coef);
        t_in_item it;
        it = rand_bits();
        it.req_type = REQ_BIAS;
        it.out_channel_index = 4'(o);
        it.coefficient = coef;
        return it;
    endfunction

    task automatic send(input t_in_item it);
        i_item <= it;
        push <= 1'b1;
        do @(posedge i_clk); while (full);
        n_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 4)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        // Requests without results may still be in the pipeline.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_cfg(input int ic, input int oc, input int kt, input int ws,
                           input int pad);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_IN_CH;  i_cfg_data <= 5'(ic);  @(posedge i_clk);
        i_cfg_idx <= CFG_OUT_CH; i_cfg_data <= 5'(oc);  @(posedge i_clk);
        i_cfg_idx <= CFG_KT;     i_cfg_data <= 5'(kt);  @(posedge i_clk);
        i_cfg_idx <= CFG_WS;     i_cfg_data <= 5'(ws);  @(posedge i_clk);
        i_cfg_idx <= CFG_PAD;    i_cfg_data <= 5'(pad); @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_ic = (ic % 32 < 1) ? 1 : ((ic % 32 > 16) ? 16 : ic % 32);
        cur_oc = (oc % 32 < 1) ? 1 : ((oc % 32 > 16) ? 16 : oc % 32);
        cur_kt = (kt % 16 < 1) ? 1 : ((kt % 16 > 8) ? 8 : kt % 16);
    endtask

    task automatic load_coefs(input int n);
        for (int i = 0; i < n; i++) begin
            send(mk_weight($urandom_range(0, cur_oc - 1), $urandom_range(0, cur_kt - 1),
                           $urandom_range(0, cur_ic - 1), pick16()));
        end
        for (int o = 0; o < cur_oc; o++) send(mk_bias(o, pick16()));
    endtask

    // One sequence; the last position sometimes ends before its last channel, and
    // ignored or coefficient requests are mixed in now and then.
    task automatic run_seq(input int len);
        int chans;
        t_in_item it;
        for (int p = 0; p < len; p++) begin
            chans = cur_ic;
            if (p == len - 1 && $urandom_range(0, 4) == 0) chans = $urandom_range(1, cur_ic);
            for (int c = 0; c < chans; c++) begin
                if ($urandom_range(0, 11) == 0) begin
                    it = rand_bits();
                    if ($urandom_range(0, 1) == 0) it.req_type = REQ_NONE;
                    else it.req_type = REQ_WEIGHT;
                    send(it);
                end
                send(mk_sample(pick16(), p == len - 1 && c == chans - 1));
            end
        end
    endtask

    initial begin
        int goal;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: extreme coefficients and samples.
        send(mk_weight(0, 0, 0, 16'h1000));
        send(mk_weight(0, 1, 0, 16'h7fff));
        send(mk_weight(0, 2, 0, 16'h8000));
        send(mk_weight(15, 7, 15, 16'h8000));
        send(mk_bias(0, 16'h0080));
        send(mk_bias(15, 16'h7fff));
        send(mk_sample(16'h7fff, 1'b0));
        send(mk_sample(16'h8000, 1'b0));
        send(mk_sample(16'h0001, 1'b0));
        send(mk_sample(16'h0080, 1'b1));
        send(mk_sample(16'hffff, 1'b1));

        // One sample with wide padding gives more windows than fit in one request.
        set_cfg(1, 16, 1, 1, 3);
        send(mk_bias(3, 16'h8000));
        send(mk_weight(5, 0, 0, 16'h7fff));
        send(mk_sample(16'h0100, 1'b1));
        run_seq(2);

        // Too short for the kernel, ending early on the first channel.
        set_cfg(2, 1, 8, 1, 0);
        send(mk_sample(16'h1234, 1'b0));
        send(mk_sample(16'h0000, 1'b0));
        send(mk_sample(16'h4321, 1'b1));

        set_cfg(16, 16, 8, 8, 3);
        load_coefs(30);
        run_seq(2);
        run_seq(3);

        set_cfg(0, 0, 0, 0, 0);
        load_coefs(2);
        run_seq(5);

        set_cfg(31, 31, 15, 15, 2);
        load_coefs(10);
        run_seq(4);

        goal = n_sent + RANDOM_ITEMS;
        while (n_sent < goal) begin
            set_cfg($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 8),
                    $urandom_range(1, 8), $urandom_range(0, 3));
            load_coefs(12);
            for (int start = n_sent; n_sent - start < 40; ) run_seq($urandom_range(1, 8));
        end

        wait_idle();
        if (errors == 0 && pending == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/c1d_pkg.sv
sv/c1d_jobq.sv
sv/c1d_front.sv
sv/c1d_back.sv
sv/conv1d_stride_pad.sv
sim/conv1d_checker.sv
sim/testbench.sv
